FILE: rtl/clu_pkg.sv
// clu_pkg: shared constants, codes and slot arithmetic for the circular list deque.
// No dependencies. Used by the top level, which sizes its memory instance from it.
package clu_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // (slot + off) mod CAPACITY; both operands are below CAPACITY
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(slot) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        return (slot == SLOT_W'(CAPACITY - 1)) ? '0 : slot + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] slot);
        return (slot == '0) ? SLOT_W'(CAPACITY - 1) : slot - SLOT_W'(1);
    endfunction

endpackage

FILE: rtl/clu_ram.sv
// clu_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module clu_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/circular_list_deque_with_search_unit.sv
// circular_list_deque_with_search_unit: bounded ring deque with linear search.
// Depends on clu_pkg and clu_ram.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------------
//  request  | in        | i_in_valid / o_in_ready  | i_operation, i_value_in
//  result   | out       | o_out_valid / i_out_ready| o_value_out, o_found, o_position,
//           |           |                          | o_status, o_occupancy
//
// One item is worked at a time; o_in_ready is high only in the idle state.
// From acceptance, inserts, refusals and unused codes go straight to the emit state;
// removes pass through a read state for the entry RAM read, and a search reads n entries;
// the single RAM read port sets the search at one entry a cycle.
// The result sits in an output register, so a new item is taken while it waits;
// a finished item only stalls if the previous result is still not taken.
// Synchronous active-low reset empties the ring (head slot zero); the entry RAM is
// not cleared, since only live entries are ever read.
module circular_list_deque_with_search_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [clu_pkg::OP_W-1:0]          i_operation,
    input  logic signed [clu_pkg::DATA_W-1:0] i_value_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [clu_pkg::DATA_W-1:0] o_value_out,
    output logic                              o_found,
    output logic [clu_pkg::POS_W-1:0]         o_position,
    output logic [clu_pkg::STAT_W-1:0]        o_status,
    output logic [clu_pkg::OCC_W-1:0]         o_occupancy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // control state
    t_state                        r_state, n_state;
    logic [clu_pkg::SLOT_W-1:0]    r_head, n_head;
    logic [clu_pkg::CNT_W-1:0]     r_count, n_count;
    logic                          r_out_valid, n_out_valid;

    // working payload
    logic [clu_pkg::DATA_W-1:0]    r_value, n_value;
    logic [clu_pkg::SLOT_W-1:0]    r_scan_slot, n_scan_slot;
    logic [clu_pkg::SLOT_W-1:0]    r_idx, n_idx;
    logic [clu_pkg::DATA_W-1:0]    r_vout, n_vout;
    logic                          r_found, n_found;
    logic [clu_pkg::SLOT_W-1:0]    r_pos, n_pos;
    clu_pkg::t_status              r_status, n_status;

    // output register
    logic [clu_pkg::DATA_W-1:0]    r_o_value, n_o_value;
    logic                          r_o_found, n_o_found;
    logic [clu_pkg::POS_W-1:0]     r_o_pos, n_o_pos;
    logic [clu_pkg::STAT_W-1:0]    r_o_status, n_o_status;
    logic [clu_pkg::OCC_W-1:0]     r_o_occ, n_o_occ;

    // entry RAM port signals
    logic                          mem_we, mem_re;
    logic [clu_pkg::SLOT_W-1:0]    mem_waddr, mem_raddr, slot_tmp;
    logic [clu_pkg::DATA_W-1:0]    mem_rdata;

    logic                          is_full, is_empty, out_free;

    // Only one item is in flight, so a write and a later read of the same entry never
    // overlap: the read is always issued in a later cycle than the write.
    clu_ram #(
        .DEPTH (clu_pkg::CAPACITY),
        .WIDTH (clu_pkg::DATA_W),
        .ADDR_W(clu_pkg::SLOT_W)
    ) u_entries (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(i_value_in),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign is_full  = (r_count == clu_pkg::CNT_W'(clu_pkg::CAPACITY));
    assign is_empty = (r_count == '0);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_scan_slot = r_scan_slot;
        n_idx       = r_idx;
        n_vout      = r_vout;
        n_found     = r_found;
        n_pos       = r_pos;
        n_status    = r_status;
        n_o_value   = r_o_value;
        n_o_found   = r_o_found;
        n_o_pos     = r_o_pos;
        n_o_status  = r_o_status;
        n_o_occ     = r_o_occ;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_head;
        mem_raddr   = r_head;
        slot_tmp    = r_head;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value  = i_value_in;
                    n_vout   = '0;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_status = clu_pkg::ST_OK;
                    n_state  = S_EMIT;
                    unique case (i_operation)
                        clu_pkg::OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = clu_pkg::ST_FULL;
                            end else begin
                                slot_tmp  = clu_pkg::slot_dec(r_head);
                                mem_we    = 1'b1;
                                mem_waddr = slot_tmp;
                                n_head    = slot_tmp;
                                n_count   = r_count + clu_pkg::CNT_W'(1);
                            end
                        end
                        clu_pkg::OP_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = clu_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = clu_pkg::slot_add(r_head, r_count);
                                n_count   = r_count + clu_pkg::CNT_W'(1);
                            end
                        end
                        clu_pkg::OP_POP_FRONT: begin
                            if (is_empty) begin
                                n_status = clu_pkg::ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_head    = clu_pkg::slot_inc(r_head);
                                n_count   = r_count - clu_pkg::CNT_W'(1);
                                n_state   = S_READ;
                            end
                        end
                        clu_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                n_status = clu_pkg::ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = clu_pkg::slot_add(r_head,
                                                r_count - clu_pkg::CNT_W'(1));
                                n_count   = r_count - clu_pkg::CNT_W'(1);
                                n_state   = S_READ;
                            end
                        end
                        clu_pkg::OP_SEARCH: begin
                            if (!is_empty) begin
                                mem_re      = 1'b1;
                                mem_raddr   = r_head;
                                n_scan_slot = r_head;
                                n_idx       = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            // unused code: no operation
                        end
                    endcase
                end
            end
            S_READ: begin
                n_vout  = mem_rdata;
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (mem_rdata == r_value) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    n_state = S_EMIT;
                end else if (clu_pkg::CNT_W'(r_idx) + clu_pkg::CNT_W'(1) == r_count) begin
                    n_state = S_EMIT;
                end else begin
                    slot_tmp    = clu_pkg::slot_inc(r_scan_slot);
                    mem_re      = 1'b1;
                    mem_raddr   = slot_tmp;
                    n_scan_slot = slot_tmp;
                    n_idx       = r_idx + clu_pkg::SLOT_W'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_value   = r_vout;
                    n_o_found   = r_found;
                    n_o_pos     = clu_pkg::POS_W'(r_pos);
                    n_o_status  = r_status;
                    n_o_occ     = clu_pkg::OCC_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_scan_slot <= n_scan_slot;
        r_idx       <= n_idx;
        r_vout      <= n_vout;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_status    <= n_status;
        r_o_value   <= n_o_value;
        r_o_found   <= n_o_found;
        r_o_pos     <= n_o_pos;
        r_o_status  <= n_o_status;
        r_o_occ     <= n_o_occ;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value_out = r_o_value;
    assign o_found     = r_o_found;
    assign o_position  = r_o_pos;
    assign o_status    = r_o_status;
    assign o_occupancy = r_o_occ;

endmodule

FILE: tb/sv/ring_tracker_pkg.sv
// ring_tracker_pkg: shadow copy of the deque ring, the queue of results it predicts
// and the field-by-field result check. Depends on clu_pkg for widths and codes.
package ring_tracker_pkg;
    import clu_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              found;
        logic [POS_W-1:0]  position;
        t_status           status;
        logic [OCC_W-1:0]  occupancy;
    } ring_result_t;

    class ring_tracker;
        logic [DATA_W-1:0] slots [CAPACITY];
        int                front_slot;
        int                fill;
        ring_result_t      due_results [$];
        int                mismatches;
        int                checked;
        int                searches;
        int                search_hits;
        int                full_refusals;
        int                empty_refusals;
        int                idle_codes;

        function new();
            front_slot     = 0;
            fill           = 0;
            mismatches     = 0;
            checked        = 0;
            searches       = 0;
            search_hits    = 0;
            full_refusals  = 0;
            empty_refusals = 0;
            idle_codes     = 0;
        endfunction

        function int slot_of(int offset);
            return (front_slot + offset) % CAPACITY;
        endfunction

        // Apply one accepted item to the shadow ring and queue the result it must give.
        function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] v);
            ring_result_t r;
            int           i;
            r        = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (fill == CAPACITY) begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end else if (op == OP_PUSH_FRONT) begin
                        front_slot        = slot_of(CAPACITY - 1);
                        slots[front_slot] = v;
                        fill++;
                    end else begin
                        slots[slot_of(fill)] = v;
                        fill++;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                        empty_refusals++;
                    end else if (op == OP_POP_FRONT) begin
                        r.value    = slots[front_slot];
                        front_slot = slot_of(1);
                        fill--;
                    end else begin
                        r.value = slots[slot_of(fill - 1)];
                        fill--;
                    end
                end
                OP_SEARCH: begin
                    searches++;
                    for (i = 0; i < fill; i++) begin
                        if (!r.found && slots[slot_of(i)] == v) begin
                            r.found    = 1'b1;
                            r.position = POS_W'(i);
                        end
                    end
                    if (r.found) begin
                        search_hits++;
                    end
                end
                default: begin
                    idle_codes++;
                end
            endcase
            r.occupancy = OCC_W'(fill);
            due_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at result %0d: %s", checked, what);
        endtask

        task check_result(logic [DATA_W-1:0] value, logic found, logic [POS_W-1:0] position,
                          logic [STAT_W-1:0] status, logic [OCC_W-1:0] occupancy);
            ring_result_t e;
            if (due_results.size() == 0) begin
                report_mismatch("result with no item outstanding");
                return;
            end
            e = due_results.pop_front();
            checked++;
            if (value !== e.value) begin
                report_mismatch($sformatf("value_out %0d, expected %0d",
                                          $signed(value), $signed(e.value)));
            end
            if (found !== e.found) begin
                report_mismatch($sformatf("found %b, expected %b", found, e.found));
            end
            if (position !== e.position) begin
                report_mismatch($sformatf("position %0d, expected %0d", position, e.position));
            end
            if (status !== e.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
            end
            if (occupancy !== e.occupancy) begin
                report_mismatch($sformatf("occupancy %0d, expected %0d",
                                          occupancy, e.occupancy));
            end
        endtask
    endclass

endpackage

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for the circular list deque with search.
// Depends on clu_pkg, ring_tracker_pkg and the circular_list_deque_with_search_unit RTL.
// Directed corner items, then three random phases with varied idling on both channels.
module tb_top;
    import clu_pkg::*;
    import ring_tracker_pkg::*;

    localparam int PHASE_ITEMS  = 585;
    localparam int STALL_LIMIT  = 4000;   // cycles with no item moving on either side
    localparam int LONG_HOLD    = 300;    // receiver back-pressure stretch
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE    = 8;

    // Codes beyond the five operations; the block must treat them as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_operation = OP_SEARCH;
    logic signed [DATA_W-1:0] i_value_in  = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_value_out;
    logic                     o_found;
    logic [POS_W-1:0]         o_position;
    logic [STAT_W-1:0]        o_status;
    logic [OCC_W-1:0]         o_occupancy;

    int tx_idle_pct   = 20;
    int rx_idle_pct   = 48;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // Sender's own view of the fill level, used only to steer the random mix
    int fill_level = 0;
    bit filling    = 1'b1;

    logic [DATA_W-1:0] value_pool [POOL_SIZE];
    ring_tracker       tracker;

    circular_list_deque_with_search_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value_in  (i_value_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_out (o_value_out),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side ready. A hold request from the sender loads a long stretch of
    // back-pressure, counted down here; otherwise ready drops at the phase's idle rate.
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            i_out_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: both handshakes are sampled at the edge, before any update lands.
    // Input item is noted first so the shadow is current for any result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.note_request(i_operation, i_value_in);
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_result(o_value_out, o_found, o_position, o_status, o_occupancy);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Watchdog: nothing moving for too long means a hang
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one item and hold it until taken. Valid is only dropped when a gap is
    // taken, so it never falls and rises within one step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) begin
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value_in  <= v;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill_level < CAPACITY) fill_level++;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (fill_level > 0) fill_level--;
            end
            default: begin
            end
        endcase
    endtask

    // Corner items: empty-ring refusals and search, unused codes, extreme values,
    // front-insert wrap from slot zero, fill to full, refusals when full, search
    // hitting the deepest entry and a miss on a full ring.
    task automatic run_directed();
        logic [OP_W-1:0] op;
        int              k;
        send_item(OP_SEARCH, '0);
        send_item(OP_POP_FRONT, $urandom);
        send_item(OP_POP_BACK, $urandom);
        for (op = OP_UNUSED_LO; op != OP_UNUSED_HI; op++) begin
            send_item(op, $urandom);
        end
        send_item(OP_UNUSED_HI, $urandom);
        send_item(OP_PUSH_FRONT, 32'h8000_0000);
        send_item(OP_PUSH_BACK, 32'h7fff_ffff);
        send_item(OP_PUSH_FRONT, 32'hffff_ffff);
        send_item(OP_PUSH_BACK, 32'h0000_0000);
        for (k = 0; k < CAPACITY - 5; k++) begin
            send_item((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'h1000_0000 + k);
        end
        send_item(OP_PUSH_BACK, 32'h5a5a_a5a5);
        send_item(OP_PUSH_FRONT, $urandom);
        send_item(OP_PUSH_BACK, $urandom);
        send_item(OP_SEARCH, 32'h5a5a_a5a5);
        send_item(OP_SEARCH, 32'h1234_5678);
    endtask

    // Random items. The mix swings between a filling and a draining tide so the
    // ring keeps reaching full and empty; values come half or more from a small pool so
    // searches hit and duplicates test the first-match rule.
    task automatic run_random(input int count, input bit with_hold);
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] v;
        int                roll;
        int                n;
        for (n = 0; n < count; n++) begin
            if (with_hold && n == count / 2) begin
                hold_requests++;
            end
            if (fill_level == CAPACITY && $urandom_range(3) == 0) begin
                filling = 1'b0;
            end else if (fill_level == 0 && $urandom_range(3) == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(59) == 0) begin
                filling = !filling;
            end
            if ($urandom_range(15) == 0) begin
                value_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
            end
            roll = $urandom_range(99);
            if (roll < 3) begin
                op = OP_UNUSED_LO + OP_W'($urandom_range(OP_UNUSED_HI - OP_UNUSED_LO));
            end else if (roll < 18) begin
                op = OP_SEARCH;
            end else if (roll < (filling ? 80 : 35)) begin
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else begin
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
            end
            // Searches lean harder on the pool than inserts do
            if ($urandom_range(99) < ((op == OP_SEARCH) ? 75 : 50)) begin
                v = value_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                v = $urandom;
            end
            send_item(op, v);
        end
    endtask

    initial begin
        tracker    = new();
        value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                       32'h0000_0001, 32'hdead_0001, 32'h0f0f_f0f0, 32'h1357_9bdf};

        // Synchronous reset, held low from time zero
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily; one long receiver hold mid-phase
        tx_idle_pct = 20;
        rx_idle_pct = 48;
        run_directed();
        run_random(PHASE_ITEMS, 1'b1);

        // Roles swapped
        tx_idle_pct = 48;
        rx_idle_pct = 20;
        run_random(PHASE_ITEMS, 1'b0);

        // Full rate on both sides, with another long hold to back the block up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS, 1'b1);
        i_in_valid <= 1'b0;

        while (tracker.due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results: %0d searches with %0d hits, %0d unused codes",
                 tracker.checked, tracker.searches, tracker.search_hits, tracker.idle_codes);
        $display("refusals seen: %0d on a full ring, %0d on an empty ring; %0d mismatches",
                 tracker.full_refusals, tracker.empty_refusals, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
